// ===== sv/bprt_pkg.sv =====
`timescale 1ns / 1ps

package bprt_pkg;

    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned MINUTES_W = 6;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned RUN_MS_W  = 22;  // 63 * 60000 fits in 22 bits
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [RUN_MS_W-1:0]  MS_PER_MINUTE       = RUN_MS_W'(60000);
    localparam logic [SPEED_W-1:0]   SPEED_RESET         = SPEED_W'(15);
    localparam logic [MINUTES_W-1:0] MINUTES_RESET       = MINUTES_W'(5);
    localparam logic [SPEED_W-1:0]   SPEED_MIN_RESET     = SPEED_W'(1);
    localparam logic [SPEED_W-1:0]   SPEED_MAX_RESET     = SPEED_W'(30);
    localparam logic [MINUTES_W-1:0] MINUTES_LIMIT_RESET = MINUTES_W'(10);
    localparam logic [MINUTES_W-1:0] MINUTES_WRAP        = MINUTES_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_MIN     = 2'd0,
        CFG_SPEED_MAX     = 2'd1,
        CFG_MINUTES_LIMIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0]   speed_min;
        logic [SPEED_W-1:0]   speed_max;
        logic [MINUTES_W-1:0] minutes_limit;
    } cfg_t;

    typedef struct packed {
        logic              on_first;
        logic              on_confirm;
        logic              up_first;
        logic              up_confirm;
        logic              down_first;
        logic              down_confirm;
        logic              minutes_first;
        logic              minutes_confirm;
        logic              stop_released;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic                 power;
        logic [SPEED_W-1:0]   speed;
        logic [MINUTES_W-1:0] minutes;
        logic [TIME_W-1:0]    start_time;
        logic                 armed_on;
        logic                 armed_up;
        logic                 armed_down;
        logic                 armed_minutes;
    } state_t;

    typedef struct packed {
        logic                 power_on;
        logic                 drive_active;
        logic [SPEED_W-1:0]   speed_value;
        logic [MINUTES_W-1:0] run_minutes;
    } result_t;

endpackage

// ===== sv/button_panel_run_timer.sv =====
`timescale 1ns / 1ps

// Button panel and run timer for a timed motor drive. Each input transfer is one pass of
// the control loop: four debounced buttons (first read and confirm read), an emergency
// stop level and a millisecond timestamp; each pass returns exactly one result transfer
// with the power state, whether the drive is active, the clamped speed and the run
// minutes. The block takes one item per clock cycle while the result side keeps up: a
// transfer lands in an input register, the step logic runs between that register and
// the result register, and the panel state is updated at the same edge as the result
// register. While a result waits, one more item can be taken into the input register;
// after that the input stalls until the result is taken. Configuration (speed range and
// minutes limit) is written through the cfg port, which is always ready; writes to an
// unused index are dropped. Write the configuration only while no item is in flight.
module button_panel_run_timer (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bprt_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [bprt_pkg::SPEED_W-1:0]         cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_on_first,
    input  logic                                 s_on_confirm,
    input  logic                                 s_up_first,
    input  logic                                 s_up_confirm,
    input  logic                                 s_down_first,
    input  logic                                 s_down_confirm,
    input  logic                                 s_minutes_first,
    input  logic                                 s_minutes_confirm,
    input  logic                                 s_stop_released,
    input  logic [bprt_pkg::TIME_W-1:0]          s_now_ms,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_power_on,
    output logic                                 m_drive_active,
    output logic [bprt_pkg::SPEED_W-1:0]         m_speed_value,
    output logic [bprt_pkg::MINUTES_W-1:0]       m_run_minutes
);

    bprt_pkg::cfg_t    cfg_reg;
    bprt_pkg::state_t  state_reg;
    bprt_pkg::state_t  state_next;
    bprt_pkg::item_t   item_reg;
    bprt_pkg::item_t   item_in;
    bprt_pkg::result_t result_reg;
    bprt_pkg::result_t result_next;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    // The step stage moves when it holds an item and the result register is free or
    // being emptied in this cycle.
    assign advance   = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;

    assign item_in.on_first        = s_on_first;
    assign item_in.on_confirm      = s_on_confirm;
    assign item_in.up_first        = s_up_first;
    assign item_in.up_confirm      = s_up_confirm;
    assign item_in.down_first      = s_down_first;
    assign item_in.down_confirm    = s_down_confirm;
    assign item_in.minutes_first   = s_minutes_first;
    assign item_in.minutes_confirm = s_minutes_confirm;
    assign item_in.stop_released   = s_stop_released;
    assign item_in.now_ms          = s_now_ms;

    bprt_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_min     <= bprt_pkg::SPEED_MIN_RESET;
            cfg_reg.speed_max     <= bprt_pkg::SPEED_MAX_RESET;
            cfg_reg.minutes_limit <= bprt_pkg::MINUTES_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (bprt_pkg::cfg_idx_t'(cfg_addr))
                bprt_pkg::CFG_SPEED_MIN: begin
                    cfg_reg.speed_min <= cfg_data;
                end
                bprt_pkg::CFG_SPEED_MAX: begin
                    cfg_reg.speed_max <= cfg_data;
                end
                bprt_pkg::CFG_MINUTES_LIMIT: begin
                    cfg_reg.minutes_limit <= cfg_data[bprt_pkg::MINUTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: loaded on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_in;
        end
    end

    // Panel state advances once per item, together with the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.power         <= 1'b0;
            state_reg.speed         <= bprt_pkg::SPEED_RESET;
            state_reg.minutes       <= bprt_pkg::MINUTES_RESET;
            state_reg.start_time    <= '0;
            state_reg.armed_on      <= 1'b0;
            state_reg.armed_up      <= 1'b0;
            state_reg.armed_down    <= 1'b0;
            state_reg.armed_minutes <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_power_on     = result_reg.power_on;
    assign m_drive_active = result_reg.drive_active;
    assign m_speed_value  = result_reg.speed_value;
    assign m_run_minutes  = result_reg.run_minutes;

endmodule

// ===== sv/bprt_step.sv =====
`timescale 1ns / 1ps

// One pass of the panel loop: button handling, run timer check and speed clamp.
module bprt_step (
    input  bprt_pkg::item_t   item,
    input  bprt_pkg::state_t  state,
    input  bprt_pkg::cfg_t    cfg,
    output bprt_pkg::state_t  state_next,
    output bprt_pkg::result_t result
);

    logic                                act_on;
    logic                                act_up;
    logic                                act_down;
    logic                                act_minutes;
    logic                                power_btn;
    logic [bprt_pkg::SPEED_W-1:0]        speed_up;
    logic [bprt_pkg::SPEED_W-1:0]        speed_dn;
    logic [bprt_pkg::SPEED_W-1:0]        speed_hi;
    logic [bprt_pkg::SPEED_W-1:0]        speed_clamped;
    logic [bprt_pkg::MINUTES_W:0]        minutes_inc;
    logic [bprt_pkg::MINUTES_W-1:0]      minutes_new;
    logic [bprt_pkg::RUN_MS_W-1:0]       run_ms;
    logic [bprt_pkg::TIME_W-1:0]         elapsed;
    logic                                in_time;

    always_comb begin
        act_on      = item.stop_released & item.on_first & ~state.armed_on & item.on_confirm;
        act_up      = item.stop_released & item.up_first & ~state.armed_up & item.up_confirm;
        act_down    = item.stop_released & item.down_first & ~state.armed_down
                      & item.down_confirm;
        act_minutes = item.stop_released & item.minutes_first & ~state.armed_minutes
                      & item.minutes_confirm;

        power_btn = state.power ^ act_on;

        // Up and down both wrap modulo 256 before the clamp.
        speed_up = act_up ? state.speed + 1'b1 : state.speed;
        speed_dn = act_down ? speed_up - 1'b1 : speed_up;

        // Upper bound first, lower bound second, so an inverted range ends at the minimum.
        speed_hi      = (speed_dn > cfg.speed_max) ? cfg.speed_max : speed_dn;
        speed_clamped = (speed_hi < cfg.speed_min) ? cfg.speed_min : speed_hi;

        minutes_inc = {1'b0, state.minutes} + 1'b1;
        if (!act_minutes) begin
            minutes_new = state.minutes;
        end else if (minutes_inc > {1'b0, cfg.minutes_limit}) begin
            minutes_new = bprt_pkg::MINUTES_WRAP;
        end else begin
            minutes_new = minutes_inc[bprt_pkg::MINUTES_W-1:0];
        end

        run_ms  = bprt_pkg::RUN_MS_W'(minutes_new) * bprt_pkg::MS_PER_MINUTE;
        elapsed = item.now_ms - state.start_time;
        in_time = elapsed < bprt_pkg::TIME_W'(run_ms);

        state_next.power      = power_btn & in_time;
        state_next.speed      = speed_clamped;
        state_next.minutes    = minutes_new;
        // The start time only follows the clock while power is off going into the check.
        state_next.start_time = power_btn ? state.start_time : item.now_ms;

        if (item.stop_released) begin
            state_next.armed_on      = act_on | (state.armed_on & item.on_confirm);
            state_next.armed_up      = item.up_confirm;
            state_next.armed_down    = item.down_confirm;
            state_next.armed_minutes = item.minutes_confirm;
        end else begin
            state_next.armed_on      = state.armed_on;
            state_next.armed_up      = state.armed_up;
            state_next.armed_down    = state.armed_down;
            state_next.armed_minutes = state.armed_minutes;
        end

        result.power_on     = state_next.power;
        result.drive_active = power_btn & in_time;
        result.speed_value  = speed_clamped;
        result.run_minutes  = minutes_new;
    end

endmodule
